// ===== design/kmr_pkg.sv =====
package kmr_pkg;

  // Default depth of the event store.
  localparam int unsigned STORE_DEPTH_DEF = 128;

  // Hold time in ticks after reset.
  localparam logic [15:0] LONG_PRESS_RESET = 16'd100;

  // Bit widths fixed by the item layout.
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned KEY_W  = 8;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned CNT_W  = 8;

  // One stored event: release flag above the key position.
  localparam int unsigned EVENT_W = KEY_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 3'd0,
    CMD_KEY_PRESS   = 3'd1,
    CMD_KEY_RELEASE = 3'd2,
    CMD_BTN_PRESS   = 3'd3,
    CMD_BTN_RELEASE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2
  } mode_t;

  typedef enum logic {
    SEQ_ACCEPT = 1'b0,
    SEQ_EXEC   = 1'b1
  } seq_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key_number;
    logic [7:0]       button_layer;
    logic [7:0]       current_layer;
  } item_t;

  typedef struct packed {
    logic             emit_valid;
    logic             emit_release;
    logic [KEY_W-1:0] emit_key;
    logic [1:0]       mode_now;
    logic             clear_pressed;
    logic             record_saved;
    logic [CNT_W-1:0] stored_length;
  } result_t;

  // Sequencing strobes from the top level to the step logic.
  typedef struct packed {
    logic rd_en;
    logic commit;
  } step_ctl_t;

endpackage

// ===== design/key_macro_recorder.sv =====
// Channel  | Direction | tdata fields, lowest bit up                     | tuser
// ---------+-----------+-------------------------------------------------+-------------------
// in_      | slave     | key_number[7:0], button_layer[7:0],             | cmd[2:0]
//          |           | current_layer[7:0], 8 zero bits                 |
// out_     | master    | emit_key[7:0], mode_now[1:0], clear_pressed,    | emit_valid,
//          |           | record_saved, stored_length[7:0], 4 zero bits   | emit_release
// cfg_     | write     | long_press_ticks[15:0]                          | -
//
// Every item passes two sequencer states: the first takes the transfer and issues the
// read of the event store, the second applies the step with the registered read data.
// The input is ready again in the cycle after the step commits, so a new item is
// not taken before the step of the last one has committed.
// The result sits in an output register; the next item may be taken while it
// waits, and its step holds in the second cycle until that register frees.
// Reset is synchronous and active low; it clears the mode, counters and held
// button, restores long_press_ticks to 100, and leaves the store contents as
// they are, since playback reads only entries a recording has written. The
// input is not ready while reset is held.
module key_macro_recorder #(
  parameter int unsigned STORE_DEPTH = kmr_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // key_number[7:0], button_layer[15:8], current_layer[23:16], zeros above
  input  logic [31:0] in_tdata,
  // cmd[2:0]
  input  logic [2:0]  in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // emit_key[7:0], mode_now[9:8], clear_pressed[10], record_saved[11],
  // stored_length[19:12], zeros above
  output logic [23:0] out_tdata,
  // emit_valid[0], emit_release[1]
  output logic [1:0]  out_tuser,

  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  kmr_pkg::seq_t     seq_r, seq_nxt;
  kmr_pkg::item_t    item_r;
  kmr_pkg::result_t  res;
  kmr_pkg::result_t  out_r;
  kmr_pkg::step_ctl_t ctl;
  logic              out_valid_r;
  logic [kmr_pkg::TICK_W-1:0] long_press_ticks_r;
  logic              in_xfer;
  logic              out_free;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // The sequencer: take a transfer, then commit the step once the output
  // register can hold its result.
  always_comb begin
    seq_nxt    = seq_r;
    in_tready  = 1'b0;
    ctl.rd_en  = 1'b0;
    ctl.commit = 1'b0;
    unique case (seq_r)
      kmr_pkg::SEQ_ACCEPT: begin
        in_tready = rst_n;
        ctl.rd_en = in_tvalid && rst_n;
        if (in_tvalid) begin
          seq_nxt = kmr_pkg::SEQ_EXEC;
        end
      end
      kmr_pkg::SEQ_EXEC: begin
        if (out_free) begin
          ctl.commit = 1'b1;
          seq_nxt    = kmr_pkg::SEQ_ACCEPT;
        end
      end
      default: begin
        seq_nxt = kmr_pkg::SEQ_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= kmr_pkg::SEQ_ACCEPT;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  // The item is held for the step cycle.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.cmd           <= in_tuser;
      item_r.key_number    <= in_tdata[7:0];
      item_r.button_layer  <= in_tdata[15:8];
      item_r.current_layer <= in_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_ticks_r <= kmr_pkg::LONG_PRESS_RESET;
    end else if (cfg_we) begin
      long_press_ticks_r <= cfg_wdata;
    end
  end

  kmr_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .item             (item_r),
    .long_press_ticks (long_press_ticks_r),
    .res              (res)
  );

  // Output register: loaded on commit, emptied by a transfer on the out side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_r.emit_release, out_r.emit_valid};
  assign out_tdata  = {4'b0000, out_r.stored_length, out_r.record_saved,
                       out_r.clear_pressed, out_r.mode_now, out_r.emit_key};

  // A taken transfer is always followed by a step cycle with input closed.
  a_xfer_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> seq_r == kmr_pkg::SEQ_EXEC && !in_tready)
    else $error("step cycle missing after input transfer");

  // A commit never overwrites a result that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> !out_valid_r || out_tready)
    else $error("result overwritten before transfer");

  // A commit always leaves a result on offer.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_tvalid)
    else $error("committed result not presented");

endmodule

// ===== design/kmr_ram.sv =====
module kmr_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/kmr_ctrl.sv =====
module kmr_ctrl #(
  parameter int unsigned STORE_DEPTH = kmr_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kmr_pkg::step_ctl_t            ctl,
  input  kmr_pkg::item_t                item,
  input  logic [kmr_pkg::TICK_W-1:0]    long_press_ticks,
  output kmr_pkg::result_t              res
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [kmr_pkg::CNT_W-1:0] DEPTH_L = kmr_pkg::CNT_W'(STORE_DEPTH);
  localparam logic [kmr_pkg::TICK_W-1:0] TICK_MAX = '1;
  localparam logic [kmr_pkg::CNT_W-1:0] HELD_MAX = '1;

  kmr_pkg::mode_t                mode_r, mode_nxt;
  logic [kmr_pkg::CNT_W-1:0]     entry_r, entry_nxt;
  logic [kmr_pkg::CNT_W-1:0]     rec_len_r, rec_len_nxt;
  logic [kmr_pkg::TICK_W-1:0]    tick_r, tick_nxt;
  logic [kmr_pkg::CNT_W-1:0]     held_r, held_nxt;
  logic [7:0]                    held_layer_r, held_layer_nxt;
  logic [kmr_pkg::KEY_W-1:0]     held_key_r, held_key_nxt;

  logic                          mem_we;
  logic [kmr_pkg::EVENT_W-1:0]   mem_wdata;
  logic [kmr_pkg::EVENT_W-1:0]   mem_rdata;
  logic [AW-1:0]                 mem_addr;
  logic                          ended;
  logic                          is_release;

  // The read is issued when the item is taken; the entry index does not move
  // until the commit, so one address serves both the read and the write.
  assign mem_addr = entry_r[AW-1:0];

  kmr_ram #(
    .WIDTH (kmr_pkg::EVENT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (ctl.rd_en),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  always_comb begin
    mode_nxt       = mode_r;
    entry_nxt      = entry_r;
    rec_len_nxt    = rec_len_r;
    tick_nxt       = tick_r;
    held_nxt       = held_r;
    held_layer_nxt = held_layer_r;
    held_key_nxt   = held_key_r;
    ended          = 1'b0;
    is_release     = (item.cmd == kmr_pkg::CMD_KEY_RELEASE);
    mem_we         = 1'b0;
    mem_wdata      = {is_release, item.key_number};
    res            = '0;

    unique case (item.cmd)
      kmr_pkg::CMD_TICK: begin
        if (mode_r == kmr_pkg::MODE_IDLE && held_r != '0 && tick_r >= long_press_ticks) begin
          held_nxt          = '0;
          mode_nxt          = kmr_pkg::MODE_REC;
          entry_nxt         = '0;
          res.clear_pressed = 1'b1;
        end
        if (mode_r == kmr_pkg::MODE_PLAY) begin
          if (entry_r >= rec_len_r || entry_r >= DEPTH_L) begin
            mode_nxt          = kmr_pkg::MODE_IDLE;
            entry_nxt         = '0;
            tick_nxt          = '0;
            res.clear_pressed = 1'b1;
            ended             = 1'b1;
          end else begin
            res.emit_valid   = 1'b1;
            res.emit_release = mem_rdata[kmr_pkg::KEY_W];
            res.emit_key     = mem_rdata[kmr_pkg::KEY_W-1:0];
            entry_nxt        = entry_r + 1'b1;
            tick_nxt         = '0;
          end
        end
        if (!ended && tick_nxt != TICK_MAX) begin
          tick_nxt = tick_nxt + 1'b1;
        end
      end
      kmr_pkg::CMD_KEY_PRESS, kmr_pkg::CMD_KEY_RELEASE: begin
        if (mode_r == kmr_pkg::MODE_REC &&
            !(held_layer_r == item.current_layer && held_key_r == item.key_number)) begin
          mem_we    = (entry_r < DEPTH_L) && ctl.commit;
          entry_nxt = entry_r + 1'b1;
          tick_nxt  = '0;
          if (entry_nxt >= DEPTH_L) begin
            rec_len_nxt       = entry_nxt;
            mode_nxt          = kmr_pkg::MODE_IDLE;
            entry_nxt         = '0;
            res.clear_pressed = 1'b1;
            res.record_saved  = 1'b1;
          end
        end
      end
      kmr_pkg::CMD_BTN_PRESS: begin
        if (mode_r == kmr_pkg::MODE_IDLE) begin
          if (held_r == '0) begin
            tick_nxt = '0;
          end
          if (held_r != HELD_MAX) begin
            held_nxt = held_r + 1'b1;
          end
          held_layer_nxt = item.button_layer;
          held_key_nxt   = item.key_number;
        end
      end
      kmr_pkg::CMD_BTN_RELEASE: begin
        if (mode_r == kmr_pkg::MODE_REC && held_layer_r == item.button_layer &&
            held_key_r == item.key_number) begin
          rec_len_nxt       = entry_r;
          mode_nxt          = kmr_pkg::MODE_IDLE;
          entry_nxt         = '0;
          res.clear_pressed = 1'b1;
          res.record_saved  = 1'b1;
          held_nxt          = '0;
        end else if (held_r != '0) begin
          held_nxt = held_r - 1'b1;
          if (held_nxt == '0 && mode_r == kmr_pkg::MODE_IDLE &&
              tick_r < long_press_ticks && rec_len_r != '0) begin
            mode_nxt          = kmr_pkg::MODE_PLAY;
            entry_nxt         = '0;
            res.clear_pressed = 1'b1;
          end
        end
      end
      default: begin
        // Unused command codes leave the state alone.
      end
    endcase

    res.mode_now      = mode_nxt;
    res.stored_length = rec_len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= kmr_pkg::MODE_IDLE;
      entry_r      <= '0;
      rec_len_r    <= '0;
      tick_r       <= '0;
      held_r       <= '0;
      held_layer_r <= '0;
      held_key_r   <= '0;
    end else if (ctl.commit) begin
      mode_r       <= mode_nxt;
      entry_r      <= entry_nxt;
      rec_len_r    <= rec_len_nxt;
      tick_r       <= tick_nxt;
      held_r       <= held_nxt;
      held_layer_r <= held_layer_nxt;
      held_key_r   <= held_key_nxt;
    end
  end

  // The recorded length never exceeds the store.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rec_len_r <= DEPTH_L)
    else $error("recorded length beyond store depth");

  // While recording the write pointer stays inside the store.
  a_rec_index: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == kmr_pkg::MODE_REC |-> entry_r < DEPTH_L)
    else $error("record index outside store");

  // Playback reads only entries that the last recording wrote.
  a_play_read: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit && res.emit_valid |-> mode_r == kmr_pkg::MODE_PLAY && entry_r < rec_len_r)
    else $error("replayed entry outside recorded macro");

endmodule
